FILE: rtl/lsa_pkg.sv
package lsa_pkg;

   // Normalized coordinates keep their largest magnitude in [2^39, 2^40)
   localparam int NORM_TOP = 40;
   localparam int NW = NORM_TOP + 1;

   // CORDIC gain in Q20, applied to dz through two partial products
   localparam int GAIN_FRAC = 20;
   localparam int GAIN_W = 21;
   localparam logic [GAIN_W-1:0] GAIN_Q20 = 21'd1726753;
   localparam int KW = NW + 1;

   // CORDIC datapath: x/y carry gain growth, z is in 2^-23 degree
   localparam int CW = 46;
   localparam int ZW = 34;
   localparam int AW = 16;
   localparam int ROUND_SHIFT = 16;
   localparam int ATAN_DEPTH = 32;

   localparam logic signed [ZW-1:0] HALF_TURN = 34'sd1509949440;
   localparam logic signed [ZW-1:0] ANGLE_HALF_LSB = 34'sd32768;

   // Register file indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEV_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEV_MIN = 2'd1;

   typedef logic signed [ZW-1:0] angle_type;

   // round(atan(2^-i) * 180/pi * 2^23)
   localparam angle_type ATAN_TAB [0:ATAN_DEPTH-1] = '{
      34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
      34'sd30000467,  34'sd15014858,  34'sd7509261,   34'sd3754860,
      34'sd1877459,   34'sd938733,    34'sd469367,    34'sd234683,
      34'sd117342,    34'sd58671,     34'sd29335,     34'sd14668,
      34'sd7334,      34'sd3667,      34'sd1833,      34'sd917,
      34'sd458,       34'sd229,       34'sd115,       34'sd57,
      34'sd29,        34'sd14,        34'sd7,         34'sd4,
      34'sd2,         34'sd1,         34'sd0,         34'sd0
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      angle_type            z;
   } vec_type;

   typedef struct packed {
      logic valid;
      logic west;
      logic az_zero;
      logic el_zero;
   } tag_type;

   // Fold the left half plane onto the right one, starting z at +-180 deg
   function automatic vec_type pre_rotate(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
      vec_type v;
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x[CW-1]) begin
         v.x = -x;
         v.y = -y;
         v.z = y[CW-1] ? -HALF_TURN : HALF_TURN;
      end
      return v;
   endfunction

   // Clamp to +-180 deg and round half up to 1/128 degree
   function automatic logic signed [AW-1:0] round_angle(input angle_type z,
                                                        input logic zero);
      angle_type zc;
      angle_type zr;
      zc = z;
      if (z > HALF_TURN) zc = HALF_TURN;
      if (z < -HALF_TURN) zc = -HALF_TURN;
      zr = (zc + ANGLE_HALF_LSB) >>> ROUND_SHIFT;
      return zero ? '0 : zr[AW-1:0];
   endfunction

endpackage

FILE: rtl/line_of_sight_angle_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  vehicle and target x, y, z
// rsp_      out        rsp_valid/rsp_stall  azimuth, elevation (1/128 deg)
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One beat enters per cycle while req_stall is low; a beat passes the input
// difference and magnitude stages, the shift normalizer, the gain stage, the
// two CORDIC cell chains and the final angle and output registers in turn.
// Reset clears all beat valids and loads the elevation limits (90, 0 deg).
// A held result freezes the pipe only once the last stage is occupied too.
module line_of_sight_angle_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_vehicle_x,
   input  logic signed [COORD_WIDTH-1:0]        req_vehicle_y,
   input  logic signed [COORD_WIDTH-1:0]        req_vehicle_z,
   input  logic signed [COORD_WIDTH-1:0]        req_target_x,
   input  logic signed [COORD_WIDTH-1:0]        req_target_y,
   input  logic signed [COORD_WIDTH-1:0]        req_target_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lsa_pkg::AW-1:0]        rsp_azimuth,
   output logic signed [lsa_pkg::AW-1:0]        rsp_elevation,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic signed [lsa_pkg::AW-1:0]        csr_wdata
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int NT = (COORD_WIDTH - 1 > lsa_pkg::NORM_TOP - 1) ?
                       COORD_WIDTH - 1 : lsa_pkg::NORM_TOP - 1;
   localparam int MW = NT + 1;
   localparam int VW = NT + 2;
   localparam int NS = $clog2(NT + 1);
   localparam int DROP = NT - (lsa_pkg::NORM_TOP - 1);
   localparam int NSTG = CORDIC_STAGES;
   localparam int NW = lsa_pkg::NW;
   localparam int KW = lsa_pkg::KW;
   localparam int CW = lsa_pkg::CW;
   localparam int AW = lsa_pkg::AW;

   logic advance;
   logic out_load;

   // Input difference stage
   lsa_pkg::tag_type s0_tag_ff, s0_tag_in;
   logic signed [DW-1:0] s0_dx_ff, s0_dx_in, s0_dy_ff, s0_dy_in, s0_dz_ff, s0_dz_in;

   // Magnitude stage
   lsa_pkg::tag_type s1_tag_ff, s1_tag_in;
   logic signed [VW-1:0] s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in, s1_dz_ff, s1_dz_in;
   logic [MW-1:0] s1_mag_ff, s1_mag_in;
   logic signed [DW-1:0] ax, ay, az;

   // Normalizer chain links
   lsa_pkg::tag_type ntag [NS+1];
   logic signed [VW-1:0] ndx [NS+1];
   logic signed [VW-1:0] ndy [NS+1];
   logic signed [VW-1:0] ndz [NS+1];
   logic [MW-1:0] nmag [NS+1];

   // Gain stage outputs
   lsa_pkg::tag_type g_tag;
   logic signed [NW-1:0] g_x, g_y;
   logic signed [KW-1:0] g_kdz;

   // First CORDIC
   lsa_pkg::tag_type p1_tag_ff, p1_tag_in;
   lsa_pkg::vec_type p1_vec_ff, p1_vec_in;
   logic [KW-1:0] p1_kdz_ff, p1_kdz_in;
   lsa_pkg::tag_type c1_tag [NSTG+1];
   lsa_pkg::vec_type c1_vec [NSTG+1];
   logic [KW-1:0] c1_pay [NSTG+1];

   // Between the CORDICs
   lsa_pkg::tag_type f1_tag_ff, f1_tag_in;
   logic [AW-1:0] f1_az_ff, f1_az_in;
   logic signed [CW-1:0] f1_kr_ff, f1_kr_in;
   logic signed [KW-1:0] f1_kdz_ff, f1_kdz_in;

   // Second CORDIC
   lsa_pkg::tag_type p2_tag_ff, p2_tag_in;
   lsa_pkg::vec_type p2_vec_ff, p2_vec_in;
   logic [AW-1:0] p2_az_ff, p2_az_in;
   lsa_pkg::tag_type c2_tag [NSTG+1];
   lsa_pkg::vec_type c2_vec [NSTG+1];
   logic [AW-1:0] c2_pay [NSTG+1];

   // Final angle and output register
   lsa_pkg::tag_type f2_tag_ff, f2_tag_in;
   logic [AW-1:0] f2_az_ff, f2_az_in;
   logic signed [AW:0] f2_el_ff, f2_el_in;
   logic signed [AW-1:0] el_raw;
   logic signed [AW:0] el_clamp;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [AW-1:0] rsp_az_ff, rsp_az_in, rsp_el_ff, rsp_el_in;

   // Configuration
   logic signed [AW-1:0] elev_max_ff, elev_max_in, elev_min_ff, elev_min_in;

   // Freeze the pipe only when the last stage holds a beat the output cannot take
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign advance = out_load || !f2_tag_ff.valid;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Form the relative vector with dz negated, one bit wider than the inputs
   always_comb begin
      s0_tag_in = s0_tag_ff;
      s0_dx_in = s0_dx_ff;
      s0_dy_in = s0_dy_ff;
      s0_dz_in = s0_dz_ff;
      if (advance) begin
         s0_tag_in = '0;
         s0_tag_in.valid = req_valid;
         s0_dx_in = DW'(req_target_x) - DW'(req_vehicle_x);
         s0_dy_in = DW'(req_target_y) - DW'(req_vehicle_y);
         s0_dz_in = DW'(req_vehicle_z) - DW'(req_target_z);
      end
   end

   // OR the magnitudes: its leading one is the largest magnitude's
   assign ax = s0_dx_ff[DW-1] ? -s0_dx_ff : s0_dx_ff;
   assign ay = s0_dy_ff[DW-1] ? -s0_dy_ff : s0_dy_ff;
   assign az = s0_dz_ff[DW-1] ? -s0_dz_ff : s0_dz_ff;

   always_comb begin
      s1_tag_in = s1_tag_ff;
      s1_dx_in = s1_dx_ff;
      s1_dy_in = s1_dy_ff;
      s1_dz_in = s1_dz_ff;
      s1_mag_in = s1_mag_ff;
      if (advance) begin
         s1_tag_in = s0_tag_ff;
         s1_dx_in = VW'(s0_dx_ff);
         s1_dy_in = VW'(s0_dy_ff);
         s1_dz_in = VW'(s0_dz_ff);
         s1_mag_in = MW'(ax[DW-2:0] | ay[DW-2:0] | az[DW-2:0]);
      end
   end

   assign ntag[0] = s1_tag_ff;
   assign ndx[0] = s1_dx_ff;
   assign ndy[0] = s1_dy_ff;
   assign ndz[0] = s1_dz_ff;
   assign nmag[0] = s1_mag_ff;

   // Binary normalizer: halve the shift step at each cell
   for (genvar k = 0; k < NS; k++) begin : g_norm
      lsa_norm_cell #(
         .VW    (VW),
         .MW    (MW),
         .SHIFT (1 << (NS - 1 - k))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .src_tag (ntag[k]),
         .src_dx  (ndx[k]),
         .src_dy  (ndy[k]),
         .src_dz  (ndz[k]),
         .src_mag (nmag[k]),
         .dst_tag (ntag[k+1]),
         .dst_dx  (ndx[k+1]),
         .dst_dy  (ndy[k+1]),
         .dst_dz  (ndz[k+1]),
         .dst_mag (nmag[k+1])
      );
   end

   // Drop the low bits (floor) to land the top in [2^39, 2^40)
   lsa_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .src_tag (ntag[NS]),
      .src_x   ($signed(ndx[NS][VW-1:DROP])),
      .src_y   ($signed(ndy[NS][VW-1:DROP])),
      .src_z   ($signed(ndz[NS][VW-1:DROP])),
      .dst_tag (g_tag),
      .dst_x   (g_x),
      .dst_y   (g_y),
      .dst_kdz (g_kdz)
   );

   // Pre-rotate for the azimuth CORDIC
   always_comb begin
      p1_tag_in = p1_tag_ff;
      p1_vec_in = p1_vec_ff;
      p1_kdz_in = p1_kdz_ff;
      if (advance) begin
         p1_tag_in = g_tag;
         p1_vec_in = lsa_pkg::pre_rotate(CW'(g_y), CW'(g_x));
         p1_kdz_in = g_kdz;
      end
   end

   assign c1_tag[0] = p1_tag_ff;
   assign c1_vec[0] = p1_vec_ff;
   assign c1_pay[0] = p1_kdz_ff;

   for (genvar i = 0; i < NSTG; i++) begin : g_cordic_az
      lsa_cordic_cell #(
         .STAGE (i),
         .PW    (KW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .src_tag (c1_tag[i]),
         .src_vec (c1_vec[i]),
         .src_pay (c1_pay[i]),
         .dst_tag (c1_tag[i+1]),
         .dst_vec (c1_vec[i+1]),
         .dst_pay (c1_pay[i+1])
      );
   end

   // Round azimuth; hand K*r and K*dz to the elevation CORDIC
   always_comb begin
      f1_tag_in = f1_tag_ff;
      f1_az_in = f1_az_ff;
      f1_kr_in = f1_kr_ff;
      f1_kdz_in = f1_kdz_ff;
      if (advance) begin
         f1_tag_in = c1_tag[NSTG];
         f1_tag_in.el_zero = (c1_vec[NSTG].x == '0) && (c1_pay[NSTG] == '0);
         f1_az_in = lsa_pkg::round_angle(c1_vec[NSTG].z, c1_tag[NSTG].az_zero);
         f1_kr_in = c1_vec[NSTG].x;
         f1_kdz_in = $signed(c1_pay[NSTG]);
      end
   end

   always_comb begin
      p2_tag_in = p2_tag_ff;
      p2_vec_in = p2_vec_ff;
      p2_az_in = p2_az_ff;
      if (advance) begin
         p2_tag_in = f1_tag_ff;
         p2_vec_in = lsa_pkg::pre_rotate(f1_kr_ff, CW'(f1_kdz_ff));
         p2_az_in = f1_az_ff;
      end
   end

   assign c2_tag[0] = p2_tag_ff;
   assign c2_vec[0] = p2_vec_ff;
   assign c2_pay[0] = p2_az_ff;

   for (genvar i = 0; i < NSTG; i++) begin : g_cordic_el
      lsa_cordic_cell #(
         .STAGE (i),
         .PW    (AW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .src_tag (c2_tag[i]),
         .src_vec (c2_vec[i]),
         .src_pay (c2_pay[i]),
         .dst_tag (c2_tag[i+1]),
         .dst_vec (c2_vec[i+1]),
         .dst_pay (c2_pay[i+1])
      );
   end

   // Round elevation and flip its sign for a westward vector
   assign el_raw = lsa_pkg::round_angle(c2_vec[NSTG].z, c2_tag[NSTG].el_zero);

   always_comb begin
      f2_tag_in = f2_tag_ff;
      f2_az_in = f2_az_ff;
      f2_el_in = f2_el_ff;
      if (advance) begin
         f2_tag_in = c2_tag[NSTG];
         f2_az_in = c2_pay[NSTG];
         f2_el_in = c2_tag[NSTG].west ? -(AW+1)'(el_raw) : (AW+1)'(el_raw);
      end
   end

   // Clamp to max first, then min
   always_comb begin
      el_clamp = f2_el_ff;
      if (el_clamp > (AW+1)'(elev_max_ff)) el_clamp = (AW+1)'(elev_max_ff);
      if (el_clamp < (AW+1)'(elev_min_ff)) el_clamp = (AW+1)'(elev_min_ff);
   end

   // Output register: load when empty or taken, hold otherwise
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_az_in = rsp_az_ff;
      rsp_el_in = rsp_el_ff;
      if (out_load) begin
         rsp_valid_in = f2_tag_ff.valid;
         rsp_az_in = $signed(f2_az_ff);
         rsp_el_in = el_clamp[AW-1:0];
      end
   end

   // Write the elevation limits; drop unknown indexes
   always_comb begin
      elev_max_in = elev_max_ff;
      elev_min_in = elev_min_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lsa_pkg::CSR_ELEV_MAX: elev_max_in = csr_wdata;
            lsa_pkg::CSR_ELEV_MIN: elev_min_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
         s1_tag_ff <= '0;
         p1_tag_ff <= '0;
         f1_tag_ff <= '0;
         p2_tag_ff <= '0;
         f2_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
         elev_max_ff <= 16'sd11520;
         elev_min_ff <= 16'sd0;
      end else begin
         s0_tag_ff <= s0_tag_in;
         s1_tag_ff <= s1_tag_in;
         p1_tag_ff <= p1_tag_in;
         f1_tag_ff <= f1_tag_in;
         p2_tag_ff <= p2_tag_in;
         f2_tag_ff <= f2_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         elev_max_ff <= elev_max_in;
         elev_min_ff <= elev_min_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_dx_ff <= s0_dx_in;
      s0_dy_ff <= s0_dy_in;
      s0_dz_ff <= s0_dz_in;
      s1_dx_ff <= s1_dx_in;
      s1_dy_ff <= s1_dy_in;
      s1_dz_ff <= s1_dz_in;
      s1_mag_ff <= s1_mag_in;
      p1_vec_ff <= p1_vec_in;
      p1_kdz_ff <= p1_kdz_in;
      f1_az_ff <= f1_az_in;
      f1_kr_ff <= f1_kr_in;
      f1_kdz_ff <= f1_kdz_in;
      p2_vec_ff <= p2_vec_in;
      p2_az_ff <= p2_az_in;
      f2_az_ff <= f2_az_in;
      f2_el_ff <= f2_el_in;
      rsp_az_ff <= rsp_az_in;
      rsp_el_ff <= rsp_el_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_azimuth = rsp_az_ff;
   assign rsp_elevation = rsp_el_ff;

   // Input stalls only behind a full, stalled output and an occupied last stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && f2_tag_ff.valid))
      else $error("input stalled without a blocked output");

   // A frozen pipe keeps its last beat
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> f2_tag_ff.valid)
      else $error("last stage lost its beat while frozen");

   // Normalizer leaves the leading one at the top of a nonzero magnitude
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      (ntag[NS].valid && (nmag[NS] != '0)) |-> nmag[NS][MW-1])
      else $error("normalizer left leading zeros");

   // Azimuth stays within +-180 degrees
   a_az_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_azimuth >= -16'sd23040) && (rsp_azimuth <= 16'sd23040))
      else $error("azimuth out of range");

endmodule

FILE: rtl/lsa_norm_cell.sv
module lsa_norm_cell #(
   parameter int VW = 41,
   parameter int MW = 40,
   parameter int SHIFT = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  lsa_pkg::tag_type        src_tag,
   input  logic signed [VW-1:0]    src_dx,
   input  logic signed [VW-1:0]    src_dy,
   input  logic signed [VW-1:0]    src_dz,
   input  logic [MW-1:0]           src_mag,
   output lsa_pkg::tag_type        dst_tag,
   output logic signed [VW-1:0]    dst_dx,
   output logic signed [VW-1:0]    dst_dy,
   output logic signed [VW-1:0]    dst_dz,
   output logic [MW-1:0]           dst_mag
);

   lsa_pkg::tag_type tag_ff, tag_in;
   logic signed [VW-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic hit;

   // Shift when the top SHIFT bits of the combined magnitude are clear
   assign hit = (src_mag[MW-1 -: SHIFT] == '0);

   always_comb begin
      tag_in = tag_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      dz_in = dz_ff;
      mag_in = mag_ff;
      if (en) begin
         tag_in = src_tag;
         if (hit) begin
            dx_in = src_dx <<< SHIFT;
            dy_in = src_dy <<< SHIFT;
            dz_in = src_dz <<< SHIFT;
            mag_in = src_mag << SHIFT;
         end else begin
            dx_in = src_dx;
            dy_in = src_dy;
            dz_in = src_dz;
            mag_in = src_mag;
         end
      end
   end

   // Clear the beat valid on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
      mag_ff <= mag_in;
   end

   assign dst_tag = tag_ff;
   assign dst_dx = dx_ff;
   assign dst_dy = dy_ff;
   assign dst_dz = dz_ff;
   assign dst_mag = mag_ff;

endmodule

FILE: rtl/lsa_gain.sv
module lsa_gain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  lsa_pkg::tag_type              src_tag,
   input  logic signed [lsa_pkg::NW-1:0] src_x,
   input  logic signed [lsa_pkg::NW-1:0] src_y,
   input  logic signed [lsa_pkg::NW-1:0] src_z,
   output lsa_pkg::tag_type              dst_tag,
   output logic signed [lsa_pkg::NW-1:0] dst_x,
   output logic signed [lsa_pkg::NW-1:0] dst_y,
   output logic signed [lsa_pkg::KW-1:0] dst_kdz
);

   localparam int NW = lsa_pkg::NW;
   localparam int FR = lsa_pkg::GAIN_FRAC;
   localparam int GW = lsa_pkg::GAIN_W;
   localparam int HW = NW - FR;
   localparam int PLW = FR + GW;
   localparam int PHW = HW + GW + 1;
   localparam int LW = PLW + 1;
   localparam int CAW = LW - FR;
   localparam logic [LW-1:0] LO_HALF = LW'(1) << (FR - 1);

   lsa_pkg::tag_type s1_tag_ff, s1_tag_in, s2_tag_ff, s2_tag_in;
   logic signed [NW-1:0] s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic signed [NW-1:0] s2_x_ff, s2_x_in, s2_y_ff, s2_y_in;
   logic [PLW-1:0] s1_plo_ff, s1_plo_in;
   logic signed [PHW-1:0] s1_phi_ff, s1_phi_in;
   logic signed [lsa_pkg::KW-1:0] s2_kdz_ff, s2_kdz_in;
   logic [PLW-1:0] plo;
   logic signed [PHW-1:0] phi;
   logic [LW-1:0] lo_rnd;
   logic signed [PHW-1:0] kdz_full;

   // Split dz into an unsigned low part and a signed high part
   assign plo = {{GW{1'b0}}, src_z[FR-1:0]} * {{FR{1'b0}}, lsa_pkg::GAIN_Q20};
   assign phi = $signed({{(GW+1){src_z[NW-1]}}, src_z[NW-1:FR]})
              * $signed({{HW{1'b0}}, 1'b0, lsa_pkg::GAIN_Q20});

   // Recombine: high product plus the rounded carry out of the low product
   assign lo_rnd = {1'b0, s1_plo_ff} + LO_HALF;
   assign kdz_full = s1_phi_ff + $signed({{(PHW-CAW){1'b0}}, lo_rnd[LW-1:FR]});

   always_comb begin
      s1_tag_in = s1_tag_ff;
      s1_x_in = s1_x_ff;
      s1_y_in = s1_y_ff;
      s1_plo_in = s1_plo_ff;
      s1_phi_in = s1_phi_ff;
      s2_tag_in = s2_tag_ff;
      s2_x_in = s2_x_ff;
      s2_y_in = s2_y_ff;
      s2_kdz_in = s2_kdz_ff;
      if (en) begin
         s1_tag_in = src_tag;
         s1_tag_in.west = src_x[NW-1];
         s1_tag_in.az_zero = (src_x == '0) && (src_y == '0);
         s1_x_in = src_x;
         s1_y_in = src_y;
         s1_plo_in = plo;
         s1_phi_in = phi;
         s2_tag_in = s1_tag_ff;
         s2_x_in = s1_x_ff;
         s2_y_in = s1_y_ff;
         s2_kdz_in = kdz_full[lsa_pkg::KW-1:0];
      end
   end

   // Clear beat valids on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s2_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff <= s1_x_in;
      s1_y_ff <= s1_y_in;
      s1_plo_ff <= s1_plo_in;
      s1_phi_ff <= s1_phi_in;
      s2_x_ff <= s2_x_in;
      s2_y_ff <= s2_y_in;
      s2_kdz_ff <= s2_kdz_in;
   end

   assign dst_tag = s2_tag_ff;
   assign dst_x = s2_x_ff;
   assign dst_y = s2_y_ff;
   assign dst_kdz = s2_kdz_ff;

endmodule

FILE: rtl/lsa_cordic_cell.sv
module lsa_cordic_cell #(
   parameter int STAGE = 0,
   parameter int PW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  lsa_pkg::tag_type  src_tag,
   input  lsa_pkg::vec_type  src_vec,
   input  logic [PW-1:0]     src_pay,
   output lsa_pkg::tag_type  dst_tag,
   output lsa_pkg::vec_type  dst_vec,
   output logic [PW-1:0]     dst_pay
);

   lsa_pkg::tag_type tag_ff, tag_in;
   lsa_pkg::vec_type vec_ff, vec_in;
   logic [PW-1:0] pay_ff, pay_in;
   logic signed [lsa_pkg::CW-1:0] xs, ys;

   assign xs = $signed(src_vec.x) >>> STAGE;
   assign ys = $signed(src_vec.y) >>> STAGE;

   // Rotate toward y = 0; y of zero counts as positive
   always_comb begin
      tag_in = tag_ff;
      vec_in = vec_ff;
      pay_in = pay_ff;
      if (en) begin
         tag_in = src_tag;
         pay_in = src_pay;
         if (!src_vec.y[lsa_pkg::CW-1]) begin
            vec_in.x = src_vec.x + ys;
            vec_in.y = src_vec.y - xs;
            vec_in.z = src_vec.z + lsa_pkg::ATAN_TAB[STAGE];
         end else begin
            vec_in.x = src_vec.x - ys;
            vec_in.y = src_vec.y + xs;
            vec_in.z = src_vec.z - lsa_pkg::ATAN_TAB[STAGE];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      pay_ff <= pay_in;
   end

   assign dst_tag = tag_ff;
   assign dst_vec = vec_ff;
   assign dst_pay = pay_ff;

endmodule
